>>> rtl/tcpft_pkg.sv
// Shared constants and types for the TCP flow table.
`default_nettype none
package tcpft_pkg;
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_IDLE_TIMEOUT  = 1'b1;

   localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd60;
   localparam logic [31:0] IDLE_TIMEOUT_RESET  = 32'd300;

   typedef struct packed {
      logic [31:0] first_time;
      logic [31:0] last_time;
      logic [31:0] sent_pkts;
      logic [31:0] sent_bytes;
      logic [31:0] recv_pkts;
      logic [31:0] recv_bytes;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage
`default_nettype wire

>>> rtl/tcpft_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module tcpft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/tcp_flow_table_windowed.sv
// Top level of the windowed TCP flow table.
`default_nettype none
// Flow table of TABLE_DEPTH TCP flows. Keys sit in registers and are matched in
// parallel; times and counters sit in one RAM. A packet that needs no window close
// is first checked against the window; a non-TCP packet ends there, any other is
// matched, a SYN or a packet with no matching flow is done after the match, and a
// counter update reads the entry, then writes it back. A window close scans the RAM
// once per reported word, then fetches that word and hands it off (an empty window
// gives one scan and an empty record), then scans once more to evict idle flows,
// waiting while the result side stalls. req_stall is high for the whole of that work.
module tcp_flow_table_windowed
   import tcpft_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [31:0] req_pkt_time,
   input  wire logic        req_is_tcp,
   input  wire logic        req_is_syn,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [15:0] req_src_port_in,
   input  wire logic [15:0] req_dst_port_in,
   input  wire logic [15:0] req_payload_bytes,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [6:0]       rsp_flow_count,
   output logic             rsp_last_record,
   output logic [31:0]      rsp_flow_start,
   output logic [31:0]      rsp_flow_end,
   output logic [31:0]      rsp_flow_src_addr,
   output logic [31:0]      rsp_flow_dst_addr,
   output logic [15:0]      rsp_flow_src_port,
   output logic [15:0]      rsp_flow_dst_port,
   output logic [31:0]      rsp_sent_packets,
   output logic [31:0]      rsp_sent_bytes,
   output logic [31:0]      rsp_recv_packets,
   output logic [31:0]      rsp_recv_bytes
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_CLOSE_INIT, ST_SCAN, ST_FETCH, ST_FDATA, ST_OUT,
      ST_EVICT, ST_MATCH, ST_DECIDE, ST_UPD_RD, ST_UPD_WR
   } state_type;

   state_type state_ff;

   logic [31:0] wl_ff, idle_ff, wb_ff, wend_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, emitted_ff;
   logic [31:0] key_src_ff [TABLE_DEPTH];
   logic [31:0] key_dst_ff [TABLE_DEPTH];
   logic [15:0] key_sp_ff  [TABLE_DEPTH];
   logic [15:0] key_dp_ff  [TABLE_DEPTH];

   // latched request
   logic        flush_ff, tcp_ff, syn_ff;
   logic [31:0] t_ff, src_ff, dst_ff;
   logic [15:0] sp_ff, dp_ff, bytes_ff;

   logic [CNT_W-1:0] scan_ff, count_ff, emit_cnt_ff;
   logic             found_ff;
   logic [IDX_W-1:0] best_ff;
   logic [31:0]      best_start_ff;

   logic             fwd_hit_ff, rev_hit_ff, free_hit_ff;
   logic [IDX_W-1:0] fwd_idx_ff, rev_idx_ff, free_idx_ff, upd_idx_ff;
   logic             upd_rev_ff;

   logic             out_valid_ff;
   logic [6:0]       out_count_ff;
   logic             out_last_ff;
   logic [31:0]      out_start_ff, out_end_ff, out_src_ff, out_dst_ff;
   logic [15:0]      out_sp_ff, out_dp_ff;
   logic [31:0]      out_spk_ff, out_sby_ff, out_rpk_ff, out_rby_ff;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   entry_type        ram_wr_data, ram_rd_data;

   tcpft_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic [IDX_W-1:0] ev_idx;
   logic             scan_last, ev_active, ev_better, ev_evict;
   logic [31:0]      clip_start;

   assign ev_idx     = IDX_W'(scan_ff - CNT_W'(1));
   assign scan_last  = (scan_ff == CNT_W'(TABLE_DEPTH));
   assign ev_active  = valid_ff[ev_idx] && (ram_rd_data.last_time > wb_ff) && !emitted_ff[ev_idx];
   assign ev_better  = !found_ff || (ram_rd_data.first_time < best_start_ff);
   assign ev_evict   = valid_ff[ev_idx] && ((wend_ff - ram_rd_data.last_time) >= idle_ff);
   assign clip_start = (ram_rd_data.first_time < wb_ff) ? wb_ff : ram_rd_data.first_time;

   // parallel key match, lowest-indexed hit wins
   logic             fwd_hit, rev_hit, free_hit;
   logic [IDX_W-1:0] fwd_idx, rev_idx, free_idx;
   always_comb begin
      fwd_hit  = 1'b0;
      rev_hit  = 1'b0;
      free_hit = 1'b0;
      fwd_idx  = '0;
      rev_idx  = '0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_src_ff[i] == src_ff && key_dst_ff[i] == dst_ff &&
             key_sp_ff[i] == sp_ff && key_dp_ff[i] == dp_ff) begin
            fwd_hit = 1'b1;
            fwd_idx = IDX_W'(i);
         end
         if (valid_ff[i] && key_src_ff[i] == dst_ff && key_dst_ff[i] == src_ff &&
             key_sp_ff[i] == dp_ff && key_dp_ff[i] == sp_ff) begin
            rev_hit = 1'b1;
            rev_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   logic [IDX_W-1:0] syn_idx;
   assign syn_idx = fwd_hit_ff ? fwd_idx_ff : free_idx_ff;

   always_comb begin
      ram_rd_addr = IDX_W'(scan_ff);
      ram_wr_en   = 1'b0;
      ram_wr_addr = upd_idx_ff;
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         ST_FETCH:  ram_rd_addr = best_ff;
         ST_UPD_RD: ram_rd_addr = upd_idx_ff;
         ST_FDATA: begin
            ram_wr_en              = 1'b1;
            ram_wr_addr            = best_ff;
            ram_wr_data.first_time = clip_start;
            ram_wr_data.sent_pkts  = '0;
            ram_wr_data.sent_bytes = '0;
            ram_wr_data.recv_pkts  = '0;
            ram_wr_data.recv_bytes = '0;
         end
         ST_DECIDE: begin
            ram_wr_en              = syn_ff && (fwd_hit_ff || free_hit_ff);
            ram_wr_addr            = syn_idx;
            ram_wr_data.first_time = t_ff;
            ram_wr_data.last_time  = t_ff;
            ram_wr_data.sent_pkts  = 32'd1;
            ram_wr_data.sent_bytes = 32'(bytes_ff);
            ram_wr_data.recv_pkts  = '0;
            ram_wr_data.recv_bytes = '0;
         end
         ST_UPD_WR: begin
            ram_wr_en             = 1'b1;
            ram_wr_data.last_time = t_ff;
            if (upd_rev_ff) begin
               ram_wr_data.recv_pkts  = ram_rd_data.recv_pkts + 32'd1;
               ram_wr_data.recv_bytes = ram_rd_data.recv_bytes + 32'(bytes_ff);
            end else begin
               ram_wr_data.sent_pkts  = ram_rd_data.sent_pkts + 32'd1;
               ram_wr_data.sent_bytes = ram_rd_data.sent_bytes + 32'(bytes_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= WINDOW_LENGTH_RESET;
         idle_ff      <= IDLE_TIMEOUT_RESET;
         wb_ff        <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_WINDOW_LENGTH: wl_ff   <= csr_write_data;
               CSR_IDLE_TIMEOUT:  idle_ff <= csr_write_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  flush_ff <= req_action;
                  tcp_ff   <= req_is_tcp;
                  syn_ff   <= req_is_syn;
                  t_ff     <= req_pkt_time;
                  src_ff   <= req_src_addr;
                  dst_ff   <= req_dst_addr;
                  sp_ff    <= req_src_port_in;
                  dp_ff    <= req_dst_port_in;
                  bytes_ff <= req_payload_bytes;
                  if (req_action) begin
                     state_ff <= ST_CLOSE_INIT;
                  end else begin
                     if (wb_ff == '0) wb_ff <= req_pkt_time;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if ((t_ff - wb_ff) > wl_ff) state_ff <= ST_CLOSE_INIT;
               else if (tcp_ff)            state_ff <= ST_MATCH;
               else                        state_ff <= ST_IDLE;
            end
            ST_CLOSE_INIT: begin
               emitted_ff  <= '0;
               emit_cnt_ff <= '0;
               count_ff    <= '0;
               scan_ff     <= '0;
               found_ff    <= 1'b0;
               wend_ff     <= wb_ff + wl_ff;
               state_ff    <= ST_SCAN;
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + CNT_W'(1);
               if (scan_ff != '0 && ev_active) begin
                  if (emit_cnt_ff == '0) count_ff <= count_ff + CNT_W'(1);
                  if (ev_better) begin
                     found_ff      <= 1'b1;
                     best_ff       <= ev_idx;
                     best_start_ff <= ram_rd_data.first_time;
                  end
               end
               if (scan_last) begin
                  if (found_ff || ev_active) begin
                     state_ff <= ST_FETCH;
                  end else begin
                     // empty window record
                     out_valid_ff <= 1'b1;
                     out_count_ff <= '0;
                     out_last_ff  <= 1'b1;
                     out_start_ff <= '0;
                     out_end_ff   <= '0;
                     out_src_ff   <= '0;
                     out_dst_ff   <= '0;
                     out_sp_ff    <= '0;
                     out_dp_ff    <= '0;
                     out_spk_ff   <= '0;
                     out_sby_ff   <= '0;
                     out_rpk_ff   <= '0;
                     out_rby_ff   <= '0;
                     state_ff     <= ST_OUT;
                  end
               end
            end
            ST_FETCH: state_ff <= ST_FDATA;
            ST_FDATA: begin
               out_valid_ff        <= 1'b1;
               out_count_ff        <= 7'(count_ff);
               out_last_ff         <= (emit_cnt_ff + CNT_W'(1)) == count_ff;
               out_start_ff        <= clip_start;
               out_end_ff          <= ram_rd_data.last_time;
               out_src_ff          <= key_src_ff[best_ff];
               out_dst_ff          <= key_dst_ff[best_ff];
               out_sp_ff           <= key_sp_ff[best_ff];
               out_dp_ff           <= key_dp_ff[best_ff];
               out_spk_ff          <= ram_rd_data.sent_pkts;
               out_sby_ff          <= ram_rd_data.sent_bytes;
               out_rpk_ff          <= ram_rd_data.recv_pkts;
               out_rby_ff          <= ram_rd_data.recv_bytes;
               emitted_ff[best_ff] <= 1'b1;
               emit_cnt_ff         <= emit_cnt_ff + CNT_W'(1);
               state_ff            <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  out_valid_ff <= 1'b0;
                  scan_ff      <= '0;
                  found_ff     <= 1'b0;
                  state_ff     <= (emit_cnt_ff == count_ff) ? ST_EVICT : ST_SCAN;
               end
            end
            ST_EVICT: begin
               scan_ff <= scan_ff + CNT_W'(1);
               if (scan_ff != '0 && ev_evict) valid_ff[ev_idx] <= 1'b0;
               if (scan_last) begin
                  if (flush_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     wb_ff    <= wb_ff + wl_ff;
                     state_ff <= tcp_ff ? ST_MATCH : ST_IDLE;
                  end
               end
            end
            ST_MATCH: begin
               fwd_hit_ff  <= fwd_hit;
               fwd_idx_ff  <= fwd_idx;
               rev_hit_ff  <= rev_hit;
               rev_idx_ff  <= rev_idx;
               free_hit_ff <= free_hit;
               free_idx_ff <= free_idx;
               state_ff    <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (syn_ff) begin
                  if (fwd_hit_ff || free_hit_ff) begin
                     valid_ff[syn_idx]   <= 1'b1;
                     key_src_ff[syn_idx] <= src_ff;
                     key_dst_ff[syn_idx] <= dst_ff;
                     key_sp_ff[syn_idx]  <= sp_ff;
                     key_dp_ff[syn_idx]  <= dp_ff;
                  end
                  state_ff <= ST_IDLE;
               end else if (fwd_hit_ff || rev_hit_ff) begin
                  upd_idx_ff <= fwd_hit_ff ? fwd_idx_ff : rev_idx_ff;
                  upd_rev_ff <= !fwd_hit_ff;
                  state_ff   <= ST_UPD_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_UPD_RD: state_ff <= ST_UPD_WR;
            ST_UPD_WR: state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = out_valid_ff;
   assign rsp_flow_count    = out_count_ff;
   assign rsp_last_record   = out_last_ff;
   assign rsp_flow_start    = out_start_ff;
   assign rsp_flow_end      = out_end_ff;
   assign rsp_flow_src_addr = out_src_ff;
   assign rsp_flow_dst_addr = out_dst_ff;
   assign rsp_flow_src_port = out_sp_ff;
   assign rsp_flow_dst_port = out_dp_ff;
   assign rsp_sent_packets  = out_spk_ff;
   assign rsp_sent_bytes    = out_sby_ff;
   assign rsp_recv_packets  = out_rpk_ff;
   assign rsp_recv_bytes    = out_rby_ff;
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the windowed TCP flow table.
`default_nettype none
module testbench
   import tcpft_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        action;
      logic [31:0] pkt_time;
      logic        is_tcp;
      logic        is_syn;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] payload;
   } pkt_word_t;

   typedef struct packed {
      logic [6:0]  flow_count;
      logic        last_record;
      logic [31:0] flow_start;
      logic [31:0] flow_end;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] sent_pkts;
      logic [31:0] sent_bytes;
      logic [31:0] recv_pkts;
      logic [31:0] recv_bytes;
   } flow_record_t;

   localparam int MAX_CYCLES = 5_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_WINDOW_LENGTH;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pkt_word_t   req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   flow_record_t rsp_word;

   tcp_flow_table_windowed u_top (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_word.action), .req_pkt_time(req_word.pkt_time),
      .req_is_tcp(req_word.is_tcp), .req_is_syn(req_word.is_syn),
      .req_src_addr(req_word.src_addr), .req_dst_addr(req_word.dst_addr),
      .req_src_port_in(req_word.sport), .req_dst_port_in(req_word.dport),
      .req_payload_bytes(req_word.payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_flow_count(rsp_word.flow_count), .rsp_last_record(rsp_word.last_record),
      .rsp_flow_start(rsp_word.flow_start), .rsp_flow_end(rsp_word.flow_end),
      .rsp_flow_src_addr(rsp_word.src_addr), .rsp_flow_dst_addr(rsp_word.dst_addr),
      .rsp_flow_src_port(rsp_word.sport), .rsp_flow_dst_port(rsp_word.dport),
      .rsp_sent_packets(rsp_word.sent_pkts), .rsp_sent_bytes(rsp_word.sent_bytes),
      .rsp_recv_packets(rsp_word.recv_pkts), .rsp_recv_bytes(rsp_word.recv_bytes)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted table state
   logic [31:0] win_len, idle_limit, win_begin;
   logic        tbl_valid [TABLE_DEPTH];
   logic [31:0] tbl_src [TABLE_DEPTH], tbl_dst [TABLE_DEPTH];
   logic [15:0] tbl_sport [TABLE_DEPTH], tbl_dport [TABLE_DEPTH];
   entry_type   tbl_entry [TABLE_DEPTH];

   pkt_word_t    pending_pkts [$];
   flow_record_t expected_records [$];
   int errors = 0;
   int cycle_count = 0;
   int accepted = 0;
   int sent_total = 0;

   function automatic int find_flow(logic [31:0] s, logic [31:0] d,
                                    logic [15:0] sp, logic [15:0] dp);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (tbl_valid[i] && tbl_src[i] == s && tbl_dst[i] == d &&
             tbl_sport[i] == sp && tbl_dport[i] == dp)
            return i;
      return -1;
   endfunction

   task automatic report_window();
      int order [$];
      int j;
      logic [31:0] wend;
      flow_record_t rec;
      wend = win_begin + win_len;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (tbl_valid[i] && tbl_entry[i].last_time > win_begin) begin
            j = order.size();
            while (j > 0 && tbl_entry[order[j-1]].first_time > tbl_entry[i].first_time)
               j--;
            order.insert(j, i);
         end
      if (order.size() == 0) begin
         rec = '0;
         rec.last_record = 1'b1;
         expected_records = {expected_records, rec};
      end
      foreach (order[k]) begin
         j = order[k];
         if (tbl_entry[j].first_time < win_begin) tbl_entry[j].first_time = win_begin;
         rec.flow_count = 7'(order.size());
         rec.last_record = (k == order.size() - 1);
         rec.flow_start = tbl_entry[j].first_time;
         rec.flow_end = tbl_entry[j].last_time;
         rec.src_addr = tbl_src[j];
         rec.dst_addr = tbl_dst[j];
         rec.sport = tbl_sport[j];
         rec.dport = tbl_dport[j];
         rec.sent_pkts = tbl_entry[j].sent_pkts;
         rec.sent_bytes = tbl_entry[j].sent_bytes;
         rec.recv_pkts = tbl_entry[j].recv_pkts;
         rec.recv_bytes = tbl_entry[j].recv_bytes;
         expected_records = {expected_records, rec};
         tbl_entry[j].sent_pkts = '0;
         tbl_entry[j].sent_bytes = '0;
         tbl_entry[j].recv_pkts = '0;
         tbl_entry[j].recv_bytes = '0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (tbl_valid[i] && (wend - tbl_entry[i].last_time) >= idle_limit)
            tbl_valid[i] = 1'b0;
   endtask

   task automatic apply_packet(pkt_word_t p);
      int i;
      if (p.action) begin
         report_window();
         return;
      end
      if (win_begin == 0) win_begin = p.pkt_time;
      if ((p.pkt_time - win_begin) > win_len) begin
         report_window();
         win_begin = win_begin + win_len;
      end
      if (!p.is_tcp) return;
      if (p.is_syn) begin
         i = find_flow(p.src_addr, p.dst_addr, p.sport, p.dport);
         if (i < 0) begin
            i = 0;
            while (i < TABLE_DEPTH && tbl_valid[i]) i++;
            if (i >= TABLE_DEPTH) return;
         end
         tbl_valid[i] = 1'b1;
         tbl_src[i] = p.src_addr;
         tbl_dst[i] = p.dst_addr;
         tbl_sport[i] = p.sport;
         tbl_dport[i] = p.dport;
         tbl_entry[i] = '{p.pkt_time, p.pkt_time, 32'd1, 32'(p.payload), 32'd0, 32'd0};
         return;
      end
      i = find_flow(p.src_addr, p.dst_addr, p.sport, p.dport);
      if (i >= 0) begin
         tbl_entry[i].last_time = p.pkt_time;
         tbl_entry[i].sent_pkts += 1;
         tbl_entry[i].sent_bytes += 32'(p.payload);
         return;
      end
      i = find_flow(p.dst_addr, p.src_addr, p.dport, p.sport);
      if (i >= 0) begin
         tbl_entry[i].last_time = p.pkt_time;
         tbl_entry[i].recv_pkts += 1;
         tbl_entry[i].recv_bytes += 32'(p.payload);
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // the handshake is evaluated at the rising edge; record it for the driver
   logic req_taken = 1'b0;
   always @(posedge clock) req_taken <= req_valid && !req_stall && !reset;

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            apply_packet(req_word);
            accepted++;
         end
         if (req_valid && !req_taken) begin
            // hold stalled word
         end else if (send_gap > 0 || pending_pkts.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            req_word <= pending_pkts.pop_front();
            req_valid <= 1'b1;
            send_gap = gap_len();
         end
      end
   end

   // monitor
   int stall_left = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            $error("record with none expected");
            errors++;
         end else begin
            flow_record_t e;
            e = expected_records.pop_front();
            if (e.flow_count !== rsp_word.flow_count) begin
               $error("flow_count exp %0d got %0d", e.flow_count, rsp_word.flow_count);
               errors++;
            end
            if (e.last_record !== rsp_word.last_record) begin
               $error("last_record exp %0d got %0d", e.last_record, rsp_word.last_record);
               errors++;
            end
            if (e.flow_start !== rsp_word.flow_start) begin
               $error("flow_start exp %0h got %0h", e.flow_start, rsp_word.flow_start);
               errors++;
            end
            if (e.flow_end !== rsp_word.flow_end) begin
               $error("flow_end exp %0h got %0h", e.flow_end, rsp_word.flow_end);
               errors++;
            end
            if (e.src_addr !== rsp_word.src_addr) begin
               $error("flow_src_addr exp %0h got %0h", e.src_addr, rsp_word.src_addr);
               errors++;
            end
            if (e.dst_addr !== rsp_word.dst_addr) begin
               $error("flow_dst_addr exp %0h got %0h", e.dst_addr, rsp_word.dst_addr);
               errors++;
            end
            if (e.sport !== rsp_word.sport) begin
               $error("flow_src_port exp %0h got %0h", e.sport, rsp_word.sport);
               errors++;
            end
            if (e.dport !== rsp_word.dport) begin
               $error("flow_dst_port exp %0h got %0h", e.dport, rsp_word.dport);
               errors++;
            end
            if (e.sent_pkts !== rsp_word.sent_pkts) begin
               $error("sent_packets exp %0h got %0h", e.sent_pkts, rsp_word.sent_pkts);
               errors++;
            end
            if (e.sent_bytes !== rsp_word.sent_bytes) begin
               $error("sent_bytes exp %0h got %0h", e.sent_bytes, rsp_word.sent_bytes);
               errors++;
            end
            if (e.recv_pkts !== rsp_word.recv_pkts) begin
               $error("recv_packets exp %0h got %0h", e.recv_pkts, rsp_word.recv_pkts);
               errors++;
            end
            if (e.recv_bytes !== rsp_word.recv_bytes) begin
               $error("recv_bytes exp %0h got %0h", e.recv_bytes, rsp_word.recv_bytes);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = gap_len();
         rsp_stall <= 1'b0;
      end
   end

   task automatic push_pkt(logic act, logic [31:0] t, logic tcp, logic syn,
                           logic [31:0] s, logic [31:0] d, logic [15:0] sp,
                           logic [15:0] dp, logic [15:0] b);
      pkt_word_t w;
      w = '{act, t, tcp, syn, s, d, sp, dp, b};
      pending_pkts = {pending_pkts, w};
      sent_total++;
   endtask

   task automatic wait_idle();
      while (accepted < sent_total || expected_records.size() != 0 || req_valid)
         @(posedge clock);
      // a close may still be evicting after the last record
      repeat (3 * (TABLE_DEPTH + 4)) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_WINDOW_LENGTH) win_len = val;
      else idle_limit = val;
   endtask

   // random traffic over a small pool of hosts so flows match and collide
   task automatic random_phase(int count, logic [31:0] t0, int step_max);
      logic [31:0] t, a, b;
      logic [15:0] pa, pb;
      int r;
      t = t0;
      for (int n = 0; n < count; n++) begin
         t += $urandom_range(0, step_max);
         a = 32'h0a000000 | $urandom_range(0, 5);
         b = 32'hc0a80000 | $urandom_range(0, 5);
         pa = 16'(1000 + $urandom_range(0, 3));
         pb = 16'(80 + $urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (r < 3) push_pkt(1'b1, $urandom, 1'($urandom), 1'($urandom), $urandom,
                             $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
         else if (r < 8) push_pkt(1'b0, t, 1'b0, 1'($urandom), $urandom, $urandom,
                                  16'($urandom), 16'($urandom), 16'($urandom));
         else if (r < 12) push_pkt(1'b0, t, 1'b1, 1'($urandom), $urandom, $urandom,
                                   16'($urandom), 16'($urandom), 16'($urandom));
         else if (r < 35) push_pkt(1'b0, t, 1'b1, 1'b1, a, b, pa, pb, 16'($urandom));
         else if (r < 70) push_pkt(1'b0, t, 1'b1, 1'b0, a, b, pa, pb, 16'($urandom));
         else push_pkt(1'b0, t, 1'b1, 1'b0, b, a, pb, pa, 16'($urandom));
      end
   endtask

   initial begin
      win_len = WINDOW_LENGTH_RESET;
      idle_limit = IDLE_TIMEOUT_RESET;
      win_begin = '0;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty close, time zero, extremes, both directions, full table
      push_pkt(1'b1, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0);
      push_pkt(1'b0, 32'd0, 1'b1, 1'b1, 32'd1, 32'd2, 16'd3, 16'd4, 16'd5);
      push_pkt(1'b0, 32'd10, 1'b1, 1'b1, '1, '1, '1, '1, '1);
      push_pkt(1'b0, 32'd12, 1'b1, 1'b0, '1, '1, '1, '1, '1);
      push_pkt(1'b0, 32'd15, 1'b1, 1'b1, 32'd7, 32'd8, 16'd9, 16'd10, 16'd0);
      push_pkt(1'b0, 32'd20, 1'b1, 1'b0, 32'd8, 32'd7, 16'd10, 16'd9, 16'hffff);
      push_pkt(1'b0, 32'd30, 1'b0, 1'b0, '0, '0, '0, '0, '0);
      push_pkt(1'b0, 32'd200, 1'b1, 1'b0, 32'd7, 32'd8, 16'd9, 16'd10, 16'd1);
      push_pkt(1'b0, 32'd210, 1'b1, 1'b1, 32'd7, 32'd8, 16'd9, 16'd10, 16'd2);
      for (int i = 0; i < 34; i++)
         push_pkt(1'b0, 32'd220, 1'b1, 1'b1, 32'(i), 32'hffff_0000, 16'(i), 16'd22, 16'(i));
      push_pkt(1'b1, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0);
      wait_idle();

      write_csr(CSR_WINDOW_LENGTH, 32'd0);
      write_csr(CSR_IDLE_TIMEOUT, 32'd0);
      random_phase(20, 32'd1000, 3);
      push_pkt(1'b1, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0);
      wait_idle();

      write_csr(CSR_WINDOW_LENGTH, 32'd25);
      write_csr(CSR_IDLE_TIMEOUT, 32'd100);
      random_phase(70, 32'd5000, 6);
      push_pkt(1'b1, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0);
      wait_idle();

      write_csr(CSR_WINDOW_LENGTH, 32'hffff_ffff);
      write_csr(CSR_IDLE_TIMEOUT, 32'hffff_ffff);
      random_phase(40, 32'hffff_ff00, 20);
      push_pkt(1'b1, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0);
      wait_idle();

      write_csr(CSR_WINDOW_LENGTH, 32'd1);
      write_csr(CSR_IDLE_TIMEOUT, 32'd5);
      random_phase(40, 32'h8000_0000, 4);
      push_pkt(1'b1, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0);
      wait_idle();

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
rtl/tcpft_pkg.sv
rtl/tcpft_ram.sv
rtl/tcp_flow_table_windowed.sv
dv/testbench.sv
